// ===== sv/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// shared types, constants and the crc-32 byte step for the frame deframer
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int          C_MEM_DEPTH = 64;
    localparam int          C_AW        = 6;

    // byte offsets inside a frame candidate
    localparam logic [6:0]  C_TYPE_POS  = 7'd4;
    localparam logic [6:0]  C_LEN_POS   = 7'd5;
    localparam logic [6:0]  C_HDR_BYTES = 7'd9;
    localparam logic [6:0]  C_OVERHEAD  = 7'd13;
    localparam logic [6:0]  C_KEEP      = 7'd3;

    // configuration register indexes
    localparam logic        C_REG_MAGIC = 1'b0;
    localparam logic        C_REG_MAXPL = 1'b1;

    // result kinds
    localparam logic [1:0]  C_KIND_STATUS = 2'd0;
    localparam logic [1:0]  C_KIND_DATA   = 2'd1;
    localparam logic [1:0]  C_KIND_EMPTY  = 2'd2;

    localparam logic [31:0] C_CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] C_CRC_POLY  = 32'hEDB8_8320;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_INIT, S_S_RD, S_S_USE, S_HDR, S_L_RD, S_L_USE, S_LCHK,
        S_C_RD, S_C_USE, S_T_RD, S_T_USE, S_TCHK, S_E_RD, S_E_USE, S_EMPTY,
        S_DONE, S_STATUS
    } t_state;

    typedef enum logic [1:0] {D_START, D_KEEP3, D_ONE, D_FRAME} t_drop;

    typedef enum logic [2:0] {P_HOLD, P_ZERO, P_LEN, P_TYPE, P_PAYLOAD, P_INC} t_posop;

    typedef enum logic [1:0] {LD_NONE, LD_DATA, LD_EMPTY, LD_STATUS} t_ld;

    typedef struct packed {
        logic    push;
        logic    clear;
        logic    rd;
        logic    shift_win;
        logic    crc_init;
        logic    crc_upd;
        logic    cap_len;
        logic    drop;
        t_drop   drop_sel;
        logic    bump;
        t_posop  posop;
        t_ld     ld;
    } t_cmd;

    typedef struct packed {
        logic pos_eq_fill;
        logic match;
        logic fill_gt3;
        logic start_nz;
        logic fill_lt_hdr;
        logic bad_len;
        logic fill_lt_total;
        logic pos_eq_hdr;
        logic pos_eq_crc_end;
        logic pos_eq_trl_end;
        logic crc_ok;
        logic plen_zero;
        logic out_busy;
    } t_status;

    // reflected crc-32 over one byte, one bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ C_CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/cfd_in_if.sv =====
// ----------------------------------------------------------------------------
// cfd_in_if
// input channel: command and received byte with valid/ready
// ----------------------------------------------------------------------------
interface cfd_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] in_byte;

    modport source (output valid, cmd, in_byte, input ready);
    modport sink   (input valid, cmd, in_byte, output ready);
endinterface

// ===== sv/cfd_out_if.sv =====
// ----------------------------------------------------------------------------
// cfd_out_if
// result channel: frame bytes and status with valid/ready
// ----------------------------------------------------------------------------
interface cfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  frame_type;
    logic [5:0]  payload_len;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [15:0] resync_count;
    logic        last;

    modport source (output valid, kind, frame_type, payload_len, data_byte, frame_end,
                    resync_count, last, input ready);
    modport sink   (input valid, kind, frame_type, payload_len, data_byte, frame_end,
                    resync_count, last, output ready);
endinterface

// ===== sv/cfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfd_ctrl
// sequencer for push, magic scan, length check, crc check and frame delivery
// ----------------------------------------------------------------------------
module cfd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_cmd,
    output logic             o_in_ready,
    input  cfd_pkg::t_status i_st,
    output cfd_pkg::t_cmd    o_cmd
);

    cfd_pkg::t_state r_state;
    cfd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.drop_sel   = cfd_pkg::D_ONE;
        o_cmd.posop      = cfd_pkg::P_HOLD;
        o_cmd.ld         = cfd_pkg::LD_NONE;
        case (r_state)
            cfd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd) begin
                        o_cmd.clear = 1'b1;
                        n_state     = cfd_pkg::S_STATUS;
                    end else begin
                        o_cmd.push = 1'b1;
                        n_state    = cfd_pkg::S_SCAN_INIT;
                    end
                end
            end
            cfd_pkg::S_SCAN_INIT: begin
                o_cmd.posop = cfd_pkg::P_ZERO;
                n_state     = cfd_pkg::S_S_RD;
            end
            cfd_pkg::S_S_RD: begin
                if (i_st.pos_eq_fill) begin
                    if (i_st.fill_gt3) begin
                        o_cmd.drop     = 1'b1;
                        o_cmd.drop_sel = cfd_pkg::D_KEEP3;
                        o_cmd.bump     = 1'b1;
                    end
                    n_state = cfd_pkg::S_STATUS;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = cfd_pkg::S_S_USE;
                end
            end
            cfd_pkg::S_S_USE: begin
                o_cmd.shift_win = 1'b1;
                if (i_st.match) begin
                    if (i_st.start_nz) begin
                        o_cmd.drop     = 1'b1;
                        o_cmd.drop_sel = cfd_pkg::D_START;
                        o_cmd.bump     = 1'b1;
                    end
                    n_state = cfd_pkg::S_HDR;
                end else begin
                    o_cmd.posop = cfd_pkg::P_INC;
                    n_state     = cfd_pkg::S_S_RD;
                end
            end
            cfd_pkg::S_HDR: begin
                if (i_st.fill_lt_hdr) begin
                    n_state = cfd_pkg::S_STATUS;
                end else begin
                    o_cmd.posop = cfd_pkg::P_LEN;
                    n_state     = cfd_pkg::S_L_RD;
                end
            end
            cfd_pkg::S_L_RD: begin
                if (i_st.pos_eq_hdr) begin
                    n_state = cfd_pkg::S_LCHK;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = cfd_pkg::S_L_USE;
                end
            end
            cfd_pkg::S_L_USE: begin
                o_cmd.shift_win = 1'b1;
                o_cmd.posop     = cfd_pkg::P_INC;
                n_state         = cfd_pkg::S_L_RD;
            end
            cfd_pkg::S_LCHK: begin
                if (i_st.bad_len) begin
                    o_cmd.drop = 1'b1;
                    o_cmd.bump = 1'b1;
                    n_state    = cfd_pkg::S_SCAN_INIT;
                end else if (i_st.fill_lt_total) begin
                    n_state = cfd_pkg::S_STATUS;
                end else begin
                    o_cmd.cap_len  = 1'b1;
                    o_cmd.crc_init = 1'b1;
                    o_cmd.posop    = cfd_pkg::P_TYPE;
                    n_state        = cfd_pkg::S_C_RD;
                end
            end
            cfd_pkg::S_C_RD: begin
                if (i_st.pos_eq_crc_end) begin
                    n_state = cfd_pkg::S_T_RD;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = cfd_pkg::S_C_USE;
                end
            end
            cfd_pkg::S_C_USE: begin
                o_cmd.crc_upd = 1'b1;
                o_cmd.posop   = cfd_pkg::P_INC;
                n_state       = cfd_pkg::S_C_RD;
            end
            cfd_pkg::S_T_RD: begin
                if (i_st.pos_eq_trl_end) begin
                    n_state = cfd_pkg::S_TCHK;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = cfd_pkg::S_T_USE;
                end
            end
            cfd_pkg::S_T_USE: begin
                o_cmd.shift_win = 1'b1;
                o_cmd.posop     = cfd_pkg::P_INC;
                n_state         = cfd_pkg::S_T_RD;
            end
            cfd_pkg::S_TCHK: begin
                if (!i_st.crc_ok) begin
                    o_cmd.drop = 1'b1;
                    o_cmd.bump = 1'b1;
                    n_state    = cfd_pkg::S_SCAN_INIT;
                end else if (i_st.plen_zero) begin
                    n_state = cfd_pkg::S_EMPTY;
                end else begin
                    o_cmd.posop = cfd_pkg::P_PAYLOAD;
                    n_state     = cfd_pkg::S_E_RD;
                end
            end
            cfd_pkg::S_E_RD: begin
                if (i_st.pos_eq_crc_end) begin
                    n_state = cfd_pkg::S_DONE;
                end else if (!i_st.out_busy) begin
                    o_cmd.rd = 1'b1;
                    n_state  = cfd_pkg::S_E_USE;
                end
            end
            cfd_pkg::S_E_USE: begin
                o_cmd.ld    = cfd_pkg::LD_DATA;
                o_cmd.posop = cfd_pkg::P_INC;
                n_state     = cfd_pkg::S_E_RD;
            end
            cfd_pkg::S_EMPTY: begin
                if (!i_st.out_busy) begin
                    o_cmd.ld = cfd_pkg::LD_EMPTY;
                    n_state  = cfd_pkg::S_DONE;
                end
            end
            cfd_pkg::S_DONE: begin
                o_cmd.drop     = 1'b1;
                o_cmd.drop_sel = cfd_pkg::D_FRAME;
                n_state        = cfd_pkg::S_STATUS;
            end
            cfd_pkg::S_STATUS: begin
                if (!i_st.out_busy) begin
                    o_cmd.ld = cfd_pkg::LD_STATUS;
                    n_state  = cfd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfd_pkg::S_IDLE;
            end
        endcase
    end

    // a result register load is only ever issued when it is free
    a_ld_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.ld != cfd_pkg::LD_NONE) |-> !i_st.out_busy)
        else $error("result load while result register busy");

    // new input only taken in idle
    a_rdy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == cfd_pkg::S_IDLE))
        else $error("input ready outside idle");

    // the status result always closes a transaction before the next is taken
    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.ld == cfd_pkg::LD_STATUS) |=> (r_state == cfd_pkg::S_IDLE))
        else $error("status load did not return to idle");

endmodule

// ===== sv/cfd_dp.sv =====
// ----------------------------------------------------------------------------
// cfd_dp
// byte ring buffer, scan window, crc unit, counters and result register
// ----------------------------------------------------------------------------
module cfd_dp #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_wdata,
    input  logic [7:0]        i_in_byte,
    input  cfd_pkg::t_cmd     i_cmd,
    output cfd_pkg::t_status  o_st,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_frame_type,
    output logic [5:0]        o_payload_len,
    output logic [7:0]        o_data_byte,
    output logic              o_frame_end,
    output logic [15:0]       o_resync_count,
    output logic              o_last
);

    localparam logic [6:0] C_CAP = 7'(BUFFER_BYTES);

    logic [7:0]              r_mem [cfd_pkg::C_MEM_DEPTH];
    logic [7:0]              r_rdata;
    logic [cfd_pkg::C_AW-1:0] r_head;
    logic [6:0]              r_fill;
    logic [6:0]              r_pos;
    logic [15:0]             r_resync;
    logic [31:0]             r_win;
    logic [31:0]             r_crc;
    logic [7:0]              r_type;
    logic [5:0]              r_plen;
    logic [31:0]             r_magic;
    logic [5:0]              r_max_pl;

    logic                    r_ovld;
    logic [1:0]              r_okind;
    logic [7:0]              r_otype;
    logic [5:0]              r_oplen;
    logic [7:0]              r_odata;
    logic                    r_oend;
    logic [15:0]             r_ocount;
    logic                    r_olast;

    logic [31:0]             n_win;
    logic [6:0]              n_drop;
    logic [6:0]              n_crc_end;
    logic [6:0]              n_total;

    assign n_win     = {r_win[23:0], r_rdata};
    assign n_crc_end = cfd_pkg::C_HDR_BYTES + {1'b0, r_plen};
    assign n_total   = cfd_pkg::C_OVERHEAD + {1'b0, r_win[5:0]};

    always_comb begin
        case (i_cmd.drop_sel)
            cfd_pkg::D_START: n_drop = r_pos - cfd_pkg::C_KEEP;
            cfd_pkg::D_KEEP3: n_drop = r_fill - cfd_pkg::C_KEEP;
            cfd_pkg::D_ONE:   n_drop = 7'd1;
            cfd_pkg::D_FRAME: n_drop = n_crc_end + 7'd4;
            default:          n_drop = 7'd1;
        endcase
    end

    always_comb begin
        o_st.pos_eq_fill    = (r_pos == r_fill);
        o_st.match          = (n_win == r_magic) && (r_pos >= cfd_pkg::C_KEEP);
        o_st.fill_gt3       = (r_fill > cfd_pkg::C_KEEP);
        o_st.start_nz       = (r_pos != cfd_pkg::C_KEEP);
        o_st.fill_lt_hdr    = (r_fill < cfd_pkg::C_HDR_BYTES);
        o_st.bad_len        = (r_win > {26'd0, r_max_pl}) || (n_total > C_CAP);
        o_st.fill_lt_total  = (r_fill < n_total);
        o_st.pos_eq_hdr     = (r_pos == cfd_pkg::C_HDR_BYTES);
        o_st.pos_eq_crc_end = (r_pos == n_crc_end);
        o_st.pos_eq_trl_end = (r_pos == n_crc_end + 7'd4);
        o_st.crc_ok         = (~r_crc == r_win);
        o_st.plen_zero      = (r_plen == 6'd0);
        o_st.out_busy       = r_ovld;
    end

    // buffer memory: one write port for pushes, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_fill < C_CAP)) begin
            r_mem[r_head + r_fill[cfd_pkg::C_AW-1:0]] <= i_in_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_head + r_pos[cfd_pkg::C_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_fill   <= '0;
            r_pos    <= '0;
            r_resync <= '0;
            r_magic  <= '0;
            r_max_pl <= 6'd51;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cfd_pkg::C_REG_MAGIC: r_magic  <= i_cfg_wdata;
                    cfd_pkg::C_REG_MAXPL: r_max_pl <= i_cfg_wdata[5:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear) begin
                r_fill   <= '0;
                r_resync <= '0;
            end else begin
                if (i_cmd.push && (r_fill < C_CAP)) begin
                    r_fill <= r_fill + 7'd1;
                end
                if (i_cmd.drop) begin
                    r_head <= r_head + n_drop[cfd_pkg::C_AW-1:0];
                    r_fill <= (n_drop >= r_fill) ? 7'd0 : (r_fill - n_drop);
                end
                if (i_cmd.bump && (r_resync != 16'hFFFF)) begin
                    r_resync <= r_resync + 16'd1;
                end
            end
            case (i_cmd.posop)
                cfd_pkg::P_ZERO:    r_pos <= '0;
                cfd_pkg::P_LEN:     r_pos <= cfd_pkg::C_LEN_POS;
                cfd_pkg::P_TYPE:    r_pos <= cfd_pkg::C_TYPE_POS;
                cfd_pkg::P_PAYLOAD: r_pos <= cfd_pkg::C_HDR_BYTES;
                cfd_pkg::P_INC:     r_pos <= r_pos + 7'd1;
                default: ;
            endcase
            if (i_cmd.ld != cfd_pkg::LD_NONE) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // scan window, crc and frame fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_win) begin
            r_win <= n_win;
        end
        if (i_cmd.crc_init) begin
            r_crc <= cfd_pkg::C_CRC_INIT;
        end else if (i_cmd.crc_upd) begin
            r_crc <= cfd_pkg::crc_byte(r_crc, r_rdata);
        end
        if (i_cmd.crc_upd && (r_pos == cfd_pkg::C_TYPE_POS)) begin
            r_type <= r_rdata;
        end
        if (i_cmd.cap_len) begin
            r_plen <= r_win[5:0];
        end
        // count is latched with the result so a waiting result holds steady
        case (i_cmd.ld)
            cfd_pkg::LD_DATA: begin
                r_okind  <= cfd_pkg::C_KIND_DATA;
                r_otype  <= r_type;
                r_oplen  <= r_plen;
                r_odata  <= r_rdata;
                r_oend   <= (r_pos + 7'd1 == n_crc_end);
                r_ocount <= r_resync;
                r_olast  <= 1'b0;
            end
            cfd_pkg::LD_EMPTY: begin
                r_okind  <= cfd_pkg::C_KIND_EMPTY;
                r_otype  <= r_type;
                r_oplen  <= 6'd0;
                r_odata  <= 8'd0;
                r_oend   <= 1'b1;
                r_ocount <= r_resync;
                r_olast  <= 1'b0;
            end
            cfd_pkg::LD_STATUS: begin
                r_okind  <= cfd_pkg::C_KIND_STATUS;
                r_otype  <= 8'd0;
                r_oplen  <= 6'd0;
                r_odata  <= 8'd0;
                r_oend   <= 1'b0;
                r_ocount <= r_resync;
                r_olast  <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_ovld;
    assign o_kind         = r_okind;
    assign o_frame_type   = r_otype;
    assign o_payload_len  = r_oplen;
    assign o_data_byte    = r_odata;
    assign o_frame_end    = r_oend;
    assign o_resync_count = r_ocount;
    assign o_last         = r_olast;

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= C_CAP)
        else $error("buffer fill above capacity");

    a_resync_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_resync == 16'hFFFF) && !i_cmd.clear) |=> (r_resync == 16'hFFFF))
        else $error("resync counter wrapped");

    a_drop_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.drop && (i_cmd.drop_sel == cfd_pkg::D_FRAME)) |-> (n_drop <= r_fill))
        else $error("frame drop beyond buffered bytes");

endmodule

// ===== sv/crc32_frame_resync_decoder.sv =====
// ----------------------------------------------------------------------------
// crc32_frame_resync_decoder
// magic / length / crc-32 frame deframer with resynchronization
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_ch): each transaction is a command; cmd 0 pushes
//   in_byte into the frame buffer, cmd 1 clears the buffer and resync count
//   result channel (o_out_ch): zero or more frame results (one per payload
//   byte, or one empty-frame result) and then always one status result
//   with last set; resync_count rides on every result
//   config port: i_cfg_we / i_cfg_idx / i_cfg_wdata, index 0 magic word,
//   index 1 max payload; write only while idle
// timing
//   one transaction at a time; the input is taken again after its status
//   result is loaded into the result register
//   each scan pass reads the buffered bytes one at a time (one memory
//   read port, registered read data), as do crc and payload delivery;
//   a rescan adds one more scan pass
// reset
//   synchronous active-low; buffer empty, count zero, magic 0, max payload 51
// stalls
//   results sit in one output register; the sequencer waits while it is
//   full, so a stalled receiver simply pauses delivery with nothing lost
// ----------------------------------------------------------------------------
module crc32_frame_resync_decoder #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    cfd_in_if.sink      i_in_ch,
    cfd_out_if.source   o_out_ch
);

    // command and status between the sequencer and the datapath
    cfd_pkg::t_cmd    w_cmd;
    cfd_pkg::t_status w_st;

    cfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_in_cmd   (i_in_ch.cmd),
        .o_in_ready (i_in_ch.ready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    // buffer, scan window, crc and result register
    cfd_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_byte      (i_in_ch.in_byte),
        .i_cmd          (w_cmd),
        .o_st           (w_st),
        .i_out_ready    (o_out_ch.ready),
        .o_out_valid    (o_out_ch.valid),
        .o_kind         (o_out_ch.kind),
        .o_frame_type   (o_out_ch.frame_type),
        .o_payload_len  (o_out_ch.payload_len),
        .o_data_byte    (o_out_ch.data_byte),
        .o_frame_end    (o_out_ch.frame_end),
        .o_resync_count (o_out_ch.resync_count),
        .o_last         (o_out_ch.last)
    );

endmodule
